### rtl/core/gnc_pkg.sv
package gnc_pkg;

  localparam int MAX_COLS  = 32;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int COLS_W    = 6;
  localparam int ROWS_W    = 11;
  localparam int ROW_POS_W = 10;
  localparam int ROW_LIMIT = 1024;
  localparam int VALUE_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [VALUE_W-1:0]   MARKED_VALUE  = VALUE_W'(9);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_A,
    ST_EMIT_B
  } gnc_state_t;

  typedef struct packed {
    logic take;
    logic adv;
    logic to_b;
    logic phase_b;
    logic last;
  } gnc_cmd_t;

  typedef struct packed {
    logic has_a;
    logic burst;
    logic burst_r;
    logic a_last;
    logic b_last;
  } gnc_sts_t;

endpackage

### rtl/core/gnc_in_if.sv
interface gnc_in_if ();
  logic valid;
  logic ready;
  logic cell_set;

  modport source (output valid, output cell_set, input ready);
  modport sink (input valid, input cell_set, output ready);
endinterface

### rtl/core/gnc_out_if.sv
interface gnc_out_if import gnc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] cell_value;
  logic               end_of_row;
  logic               end_of_frame;
  logic               last_in_run;

  modport source (output valid, output cell_value, output end_of_row,
                  output end_of_frame, output last_in_run, input ready);
  modport sink (input valid, input cell_value, input end_of_row,
                input end_of_frame, input last_in_run, output ready);
endinterface

### rtl/core/gnc_ctrl.sv
module gnc_ctrl import gnc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gnc_sts_t sts,
  output gnc_cmd_t cmd
);

  gnc_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  gnc_state_t plan_state;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    if (sts.has_a) begin
      plan_state = ST_EMIT_A;
    end else if (sts.burst) begin
      plan_state = ST_EMIT_B;
    end else begin
      plan_state = ST_IDLE;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.adv     = 1'b0;
    cmd.to_b    = 1'b0;
    cmd.phase_b = (state_r == ST_EMIT_B);
    cmd.last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = plan_state;
        end
      end
      ST_EMIT_A: begin
        cmd.last = sts.a_last && !sts.burst_r;
        if (out_free) begin
          cmd.adv = 1'b1;
          if (sts.a_last) begin
            if (sts.burst_r) begin
              cmd.to_b  = 1'b1;
              state_nxt = ST_EMIT_B;
            end else begin
              in_ready  = 1'b1;
              state_nxt = in_valid ? plan_state : ST_IDLE;
            end
          end
        end
      end
      ST_EMIT_B: begin
        cmd.last = sts.b_last;
        if (out_free) begin
          cmd.adv = 1'b1;
          if (sts.b_last) begin
            in_ready  = 1'b1;
            state_nxt = in_valid ? plan_state : ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.take = in_valid && in_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/gnc_dp.sv
module gnc_dp import gnc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_cell,
  input  gnc_cmd_t             cmd,
  output gnc_sts_t             sts,
  output logic [VALUE_W-1:0]   out_value,
  output logic                 out_eor,
  output logic                 out_eof,
  output logic                 out_lir
);

  localparam logic [COLS_W-1:0] MAX_COLS_V  = COLS_W'(MAX_COLS);
  localparam logic [ROWS_W-1:0] ROW_LIMIT_V = ROWS_W'(ROW_LIMIT);

  logic [ROWS_W-1:0]    grid_rows_r;
  logic [COLS_W-1:0]    grid_cols_r;
  logic [MAX_COLS-1:0]  row0_r, row1_r, row2_r;
  logic [ROW_POS_W-1:0] row_pos_r;
  logic [COL_W-1:0]     col_pos_r;
  logic [MAX_COLS-1:0]  snap_top_r, snap_mid_r, snap_bot_r;
  logic [COL_W-1:0]     ecol_r;
  logic [COL_W-1:0]     a_end_r;
  logic                 burst_r;
  logic [VALUE_W-1:0]   value_r;
  logic                 eor_r, eof_r, lir_r;

  logic [ROWS_W-1:0]    rows_eff;
  logic [COLS_W-1:0]    cols_eff;
  logic [ROW_POS_W-1:0] rows_m1;
  logic [COL_W-1:0]     cols_m1;
  logic                 one_col;
  logic                 last_row, last_col;
  logic [MAX_COLS-1:0]  row2_set;
  logic [COL_W-1:0]     a_start, a_end;
  logic                 cfg_hit;

  logic [MAX_COLS-1:0]  top_v, mid_v, bot_v;
  logic [COL_W-1:0]     c_l, c_r;
  logic                 has_l, has_r;
  logic [VALUE_W-1:0]   nb_sum, cell_val;

  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (grid_rows_r > ROW_LIMIT_V) begin
      rows_eff = ROW_LIMIT_V;
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (grid_cols_r > MAX_COLS_V) begin
      cols_eff = MAX_COLS_V;
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  assign rows_m1  = ROW_POS_W'(rows_eff - ROWS_W'(1));
  assign cols_m1  = COL_W'(cols_eff - COLS_W'(1));
  assign one_col  = (cols_eff == COLS_W'(1));
  assign last_row = (row_pos_r == rows_m1);
  assign last_col = (col_pos_r == cols_m1);

  always_comb begin
    row2_set            = row2_r;
    row2_set[col_pos_r] = row2_r[col_pos_r] | in_cell;
  end

  // emission plan for the row above
  assign a_start = one_col ? '0 : col_pos_r - COL_W'(1);
  assign a_end   = (one_col || last_col) ? col_pos_r : col_pos_r - COL_W'(1);

  assign sts.has_a   = (row_pos_r != '0) && (one_col || (col_pos_r != '0));
  assign sts.burst   = last_row && last_col;
  assign sts.burst_r = burst_r;
  assign sts.a_last  = (ecol_r == a_end_r);
  assign sts.b_last  = (ecol_r == cols_m1);

  assign cfg_hit = cfg_we && ((cfg_index == REG_GRID_ROWS) || (cfg_index == REG_GRID_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_W'(1);
      grid_cols_r <= COLS_W'(1);
      row0_r      <= '0;
      row1_r      <= '0;
      row2_r      <= '0;
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      burst_r     <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_GRID_ROWS) begin
        grid_rows_r <= cfg_wdata[ROWS_W-1:0];
      end else begin
        grid_cols_r <= cfg_wdata[COLS_W-1:0];
      end
      row0_r    <= '0;
      row1_r    <= '0;
      row2_r    <= '0;
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (cmd.take) begin
      burst_r <= sts.burst;
      if (sts.burst) begin
        row0_r    <= '0;
        row1_r    <= '0;
        row2_r    <= '0;
        row_pos_r <= '0;
        col_pos_r <= '0;
      end else if (last_col) begin
        row0_r    <= row1_r;
        row1_r    <= row2_set;
        row2_r    <= '0;
        row_pos_r <= row_pos_r + ROW_POS_W'(1);
        col_pos_r <= '0;
      end else begin
        row2_r    <= row2_set;
        col_pos_r <= col_pos_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      snap_top_r <= row0_r;
      snap_mid_r <= row1_r;
      snap_bot_r <= row2_set;
      a_end_r    <= a_end;
      ecol_r     <= sts.has_a ? a_start : '0;
    end else if (cmd.adv) begin
      ecol_r <= cmd.to_b ? '0 : ecol_r + COL_W'(1);
    end
  end

  // 3x3 count for the column under the emit pointer
  always_comb begin
    if (cmd.phase_b) begin
      top_v = snap_mid_r;
      mid_v = snap_bot_r;
      bot_v = '0;
    end else begin
      top_v = snap_top_r;
      mid_v = snap_mid_r;
      bot_v = snap_bot_r;
    end
  end

  assign c_l   = ecol_r - COL_W'(1);
  assign c_r   = ecol_r + COL_W'(1);
  assign has_l = (ecol_r != '0);
  assign has_r = (ecol_r != cols_m1);

  assign nb_sum = VALUE_W'(top_v[ecol_r]) + VALUE_W'(bot_v[ecol_r])
                + VALUE_W'(has_l & top_v[c_l]) + VALUE_W'(has_l & mid_v[c_l])
                + VALUE_W'(has_l & bot_v[c_l]) + VALUE_W'(has_r & top_v[c_r])
                + VALUE_W'(has_r & mid_v[c_r]) + VALUE_W'(has_r & bot_v[c_r]);

  assign cell_val = mid_v[ecol_r] ? MARKED_VALUE : nb_sum;

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      value_r <= cell_val;
      eor_r   <= (ecol_r == cols_m1);
      eof_r   <= cmd.phase_b && (ecol_r == cols_m1);
      lir_r   <= cmd.last;
    end
  end

  assign out_value = value_r;
  assign out_eor   = eor_r;
  assign out_eof   = eof_r;
  assign out_lir   = lir_r;

endmodule

### rtl/core/grid_eight_neighbor_count.sv
// channel  dir  payload                                              handshake
// in_ch    in   cell_set                                             valid/ready
// out_ch   out  cell_value, end_of_row, end_of_frame, last_in_run    valid/ready
// cfg      in   cfg_index, cfg_wdata (0 grid_rows, 1 grid_cols)      cfg_we
//
// an item that causes results holds the input until its last result is sent,
// one result per cycle from the emit sequencer while the output is free; an
// item with no result leaves the input ready; the last item of a frame emits
// up to two cells of the row above plus the whole last row
// reset (rst_n low, synchronous) sets both sizes to 1 and clears the frame
// a stalled output holds the sequencer; the next item is taken while the
// last result of the previous item waits in the output register
module grid_eight_neighbor_count import gnc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  gnc_in_if.sink               in_ch,
  gnc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  gnc_cmd_t cmd;
  gnc_sts_t sts;

  gnc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gnc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_cell   (in_ch.cell_set),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_ch.cell_value),
    .out_eor   (out_ch.end_of_row),
    .out_eof   (out_ch.end_of_frame),
    .out_lir   (out_ch.last_in_run)
  );

endmodule

### test/tb_top.sv
module tb_top;
  import gnc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int CLAMP_CELLS  = 12;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic               end_of_row;
    logic               end_of_frame;
    logic               last_in_run;
  } cell_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  gnc_in_if  in_ch ();
  gnc_out_if out_ch ();

  grid_eight_neighbor_count i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // neighbor count predictor state
  logic [MAX_COLS-1:0] row_buf [3];
  int                  next_row;
  int                  next_col;
  logic [ROWS_W-1:0]   rows_cfg;
  logic [COLS_W-1:0]   cols_cfg;
  cell_result_t        pending_counts [$];
  cell_result_t        want_r;

  int err_count;
  int cycle_count;
  int cells_sent;
  int counts_checked;
  int frames_done;
  int widest_row;
  int longest_burst;
  int idle_in_pct;
  int stall_out_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycle_count,
               pending_counts.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_out_pct);
  end

  function automatic int eff_rows();
    if (rows_cfg == 0) return 1;
    if (rows_cfg > ROW_LIMIT) return ROW_LIMIT;
    return int'(rows_cfg);
  endfunction

  function automatic int eff_cols();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > MAX_COLS) return MAX_COLS;
    return int'(cols_cfg);
  endfunction

  function automatic void clear_frame();
    row_buf[0] = '0;
    row_buf[1] = '0;
    row_buf[2] = '0;
    next_row = 0;
    next_col = 0;
  endfunction

  function automatic void push_count(input logic [MAX_COLS-1:0] top, mid, bot,
                                     input int c, input int cols, input logic eof);
    cell_result_t r;
    int lo;
    int hi;
    int k;
    r = '0;
    if (mid[c]) begin
      r.cell_value = MARKED_VALUE;
    end else begin
      lo = (c == 0) ? 0 : c - 1;
      hi = (c + 1 < cols) ? c + 1 : c;
      for (k = lo; k <= hi; k++) begin
        r.cell_value += top[k] + bot[k];
        if (k != c) r.cell_value += mid[k];
      end
    end
    r.end_of_row   = (c == cols - 1);
    r.end_of_frame = eof;
    pending_counts.push_back(r);
  endfunction

  function automatic void predict_counts(input logic cell_bit);
    int rows;
    int cols;
    int j;
    int c;
    int n_before;
    rows = eff_rows();
    cols = eff_cols();
    if (next_col >= cols) next_col = cols - 1;
    if (next_row >= rows) next_row = rows - 1;
    j = next_col;
    n_before = pending_counts.size();
    if (cols > widest_row) widest_row = cols;
    if (cell_bit) row_buf[2][j] = 1'b1;
    // cells of the row above that fall due at this column
    if (next_row >= 1) begin
      if (cols == 1) begin
        push_count(row_buf[0], row_buf[1], row_buf[2], 0, cols, 1'b0);
      end else if (j >= 1) begin
        push_count(row_buf[0], row_buf[1], row_buf[2], j - 1, cols, 1'b0);
        if (j == cols - 1) push_count(row_buf[0], row_buf[1], row_buf[2], j, cols, 1'b0);
      end
    end
    if (next_row == rows - 1 && j == cols - 1) begin
      // last row flushes in full, bottom neighbors outside the grid
      for (c = 0; c < cols; c++)
        push_count(row_buf[1], row_buf[2], '0, c, cols, c == cols - 1);
      clear_frame();
      frames_done++;
    end else begin
      next_col = j + 1;
      if (next_col >= cols) begin
        next_col = 0;
        next_row++;
        row_buf[0] = row_buf[1];
        row_buf[1] = row_buf[2];
        row_buf[2] = '0;
      end
    end
    if (pending_counts.size() > n_before) begin
      pending_counts[pending_counts.size() - 1].last_in_run = 1'b1;
      if (pending_counts.size() - n_before > longest_burst)
        longest_burst = pending_counts.size() - n_before;
    end
  endfunction

  function automatic void check_field(input string what, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // predicts on accepted items and register writes, checks accepted counts
  always @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg = ROWS_W'(1);
      cols_cfg = COLS_W'(1);
      clear_frame();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_ROWS: begin
            rows_cfg = cfg_wdata[ROWS_W-1:0];
            clear_frame();
          end
          REG_GRID_COLS: begin
            cols_cfg = cfg_wdata[COLS_W-1:0];
            clear_frame();
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) predict_counts(in_ch.cell_set);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_counts.size() == 0) begin
          err_count++;
          $display("%0t: unexpected count, expected none, got value %0d", $time,
                   out_ch.cell_value);
        end else begin
          want_r = pending_counts.pop_front();
          check_field("cell_value", want_r.cell_value, out_ch.cell_value);
          check_field("end_of_row", want_r.end_of_row, out_ch.end_of_row);
          check_field("end_of_frame", want_r.end_of_frame, out_ch.end_of_frame);
          check_field("last_in_run", want_r.last_in_run, out_ch.last_in_run);
          counts_checked++;
        end
      end
    end
  end

  task automatic send_cell(input logic cell_bit);
    while ($urandom_range(99) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cell_set <= cell_bit;
    do @(posedge clk); while (!in_ch.ready);
    cells_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  // drained, plus time for an item with no count still in flight
  task automatic wait_idle();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DAT_W-1:0] rows_w, cols_w);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_wdata <= rows_w;
    @(posedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_wdata <= cols_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_sizes();
    send_cell(1'b1);
    send_cell(1'b0);
  endtask

  // zero sizes act as one, spare indexes change nothing
  task automatic test_zero_and_spare();
    wait_idle();
    write_regs('0, '0);
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    send_cell(1'b0);
    send_cell(1'b1);
  endtask

  task automatic test_center_and_ring();
    int k;
    wait_idle();
    write_regs(CFG_DAT_W'(3), CFG_DAT_W'(3));
    for (k = 0; k < 9; k++) begin
      send_cell(k == 4);
      if (k == 5) wait_drain();
    end
    for (k = 0; k < 9; k++) send_cell(k != 4);
  endtask

  task automatic test_single_column();
    wait_idle();
    write_regs(CFG_DAT_W'(3), CFG_DAT_W'(1));
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
  endtask

  // row count above the limit, one column, frame cut short to keep the run small
  task automatic test_row_clamp();
    int k;
    wait_idle();
    write_regs('1, CFG_DAT_W'(1));
    for (k = 0; k < CLAMP_CELLS; k++) send_cell(1'($urandom_range(1)));
  endtask

  task automatic test_random_frames(input int budget, input int lead_rows, input int lead_cols);
    int sent;
    int f;
    int cols;
    int n_cells;
    int stop_at;
    int density;
    int k;
    logic [CFG_DAT_W-1:0] rows_w;
    logic [CFG_DAT_W-1:0] cols_w;
    sent = 0;
    f = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0: cols_w = '0;
        1: cols_w = CFG_DAT_W'(1);
        2: cols_w = CFG_DAT_W'(2);
        3: cols_w = CFG_DAT_W'(MAX_COLS);
        4: cols_w = CFG_DAT_W'(($urandom_range(31) << 6) | 6'h3F);
        default: cols_w = CFG_DAT_W'($urandom_range(3, 8));
      endcase
      cols = (cols_w[COLS_W-1:0] == 0) ? 1 :
             (cols_w[COLS_W-1:0] > MAX_COLS) ? MAX_COLS : int'(cols_w[COLS_W-1:0]);
      if (cols >= 16) begin
        rows_w = CFG_DAT_W'($urandom_range(2));
      end else begin
        case ($urandom_range(5))
          0: rows_w = '0;
          1: rows_w = CFG_DAT_W'(1);
          default: rows_w = CFG_DAT_W'($urandom_range(2, 5));
        endcase
      end
      if (f == 0 && lead_cols >= 0) begin
        rows_w = CFG_DAT_W'(lead_rows);
        cols_w = CFG_DAT_W'(lead_cols);
        cols = (cols_w[COLS_W-1:0] > MAX_COLS) ? MAX_COLS : int'(cols_w[COLS_W-1:0]);
      end
      n_cells = ((rows_w == 0) ? 1 : int'(rows_w)) * cols;
      stop_at = n_cells;
      // broken frame cut short by a restart
      if (f > 0 && $urandom_range(5) == 0) stop_at = $urandom_range(n_cells - 1);
      case ($urandom_range(4))
        0: density = 0;
        1: density = 100;
        default: density = $urandom_range(5, 95);
      endcase
      wait_idle();
      write_regs(rows_w, cols_w);
      for (k = 0; k < stop_at; k++) begin
        send_cell($urandom_range(99) < density);
        if (k == stop_at / 2 && $urandom_range(7) == 0) wait_drain();
      end
      sent += stop_at;
      f++;
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cell_set <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    err_count      = 0;
    cycle_count    = 0;
    cells_sent     = 0;
    counts_checked = 0;
    frames_done    = 0;
    widest_row     = 0;
    longest_burst  = 0;
    idle_in_pct    = 21;
    stall_out_pct  = 51;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_sizes();
    test_zero_and_spare();
    test_center_and_ring();
    test_single_column();
    test_random_frames(30, 2, MAX_COLS);
    idle_in_pct   = 51;
    stall_out_pct = 21;
    test_random_frames(30, 1, 11'h7FF);
    idle_in_pct   = 0;
    stall_out_pct = 0;
    test_random_frames(30, -1, -1);
    test_row_clamp();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d cells over %0d complete frames, checked %0d counts",
             cells_sent, frames_done, counts_checked);
    $display("widest row %0d columns, longest burst %0d counts from one cell",
             widest_row, longest_burst);
    if (err_count == 0 && pending_counts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d counts never arrived", err_count,
               pending_counts.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/gnc_pkg.sv
rtl/core/gnc_in_if.sv
rtl/core/gnc_out_if.sv
rtl/core/gnc_ctrl.sv
rtl/core/gnc_dp.sv
rtl/core/grid_eight_neighbor_count.sv
test/tb_top.sv
